>>> src/mlfs_pkg.sv
// ----------------------------------------------------------------------------
// mlfs_pkg
// Types and constants shared by the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfs_pkg;

	localparam int ID_W  = 8;
	localparam int SVC_W = 16;
	localparam int RUN_W = 17;
	localparam int Q_W   = 8;
	localparam int LVL_W = 4;

	localparam logic [Q_W-1:0] QUANTUM_RESET = 8'd10;

	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_DROP   = 2'd1;
	localparam logic [1:0] KIND_RAN    = 2'd2;
	localparam logic [1:0] KIND_IDLE   = 2'd3;

	typedef struct packed {
		logic             req_type;
		logic [ID_W-1:0]  process_id;
		logic [SVC_W-1:0] service_time;
	} req_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [ID_W-1:0]  ran_id;
		logic [LVL_W-1:0] ran_level;
		logic             finished;
	} res_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [SVC_W-1:0] svc;
		logic [RUN_W-1:0] run;
	} proc_entry_t;

endpackage

`default_nettype wire

>>> src/multilevel_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multilevel feedback queue scheduler over a process store and level rings.
//
// Request channel (req_valid/req_stall/req) takes one beat per item: an
// arrival queues a process at level 0, a tick runs the head of the lowest
// numbered non-empty level for one quantum and retires it if finished, else
// demotes it (at the last level it stays at the head). Every beat gives
// exactly one result beat on res_valid/res_stall/res.
// An arrival, or a tick with nothing queued, is answered straight into the
// output register; a tick that runs a process goes through a level ring
// read, a process store read, and update and write back before its result
// is registered. The block works on one item at a time and takes no new
// beat until idle again; a tick waits on two serial synchronous memory reads.
// While the receiver stalls, the finished result waits in a hold register and
// req_stall stays high until the output register frees.
// Reset clears slot flags, level pointers and counts and sets quantum to 10;
// the memories are not cleared. cfg_we/cfg_wdata write the quantum.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_feedback_scheduler #(
	parameter int MAX_PROCS = 16,
	parameter int LEVELS    = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire mlfs_pkg::req_t               req,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output mlfs_pkg::res_t                    res,
	input  wire logic                         cfg_we,
	input  wire logic [mlfs_pkg::Q_W-1:0]     cfg_wdata
);

	localparam int SW = $clog2(MAX_PROCS);
	localparam int LW = $clog2(LEVELS);
	localparam int CW = SW + 1;
	localparam int FIFO_DEPTH = LEVELS << SW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SLOT = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0] state_q, state_d;
	logic [mlfs_pkg::Q_W-1:0] quantum_q;

	logic [MAX_PROCS-1:0] in_use_q;
	logic [SW-1:0] head_q  [LEVELS];
	logic [SW-1:0] tail_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	mlfs_pkg::proc_entry_t store_mem [MAX_PROCS];
	logic [SW-1:0]         fifo_mem  [FIFO_DEPTH];

	mlfs_pkg::proc_entry_t st_rdata_q;
	logic [SW-1:0]         ff_rdata_q;
	logic [LW-1:0]         lv_q;
	logic [SW-1:0]         slot_q;

	mlfs_pkg::res_t pend_q;
	mlfs_pkg::res_t res_q;
	logic           res_valid_q;

	logic [LW-1:0] lv_sel;
	logic          any_queued;
	logic [SW-1:0] free_slot;
	logic          any_free;

	logic accept, out_free, emit;
	mlfs_pkg::res_t res_d, emit_res;

	logic [mlfs_pkg::RUN_W-1:0] run_new;
	logic                       done;
	logic                       last_lv;
	logic [LW-1:0]              lv_next;

	logic                       st_we;
	logic [SW-1:0]              st_waddr;
	mlfs_pkg::proc_entry_t      st_wdata;
	logic                       ff_we;
	logic [LW+SW-1:0]           ff_waddr;
	logic [SW-1:0]              ff_wdata;

	int total_queued;

	assign accept   = req_valid && !req_stall;
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		lv_sel     = '0;
		any_queued = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				lv_sel     = LW'(i);
				any_queued = 1'b1;
			end
		end
	end

	always_comb begin
		free_slot = '0;
		any_free  = 1'b0;
		for (int i = MAX_PROCS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_slot = SW'(i);
				any_free  = 1'b1;
			end
		end
	end

	assign run_new = st_rdata_q.run + mlfs_pkg::RUN_W'(quantum_q);
	assign done    = run_new >= mlfs_pkg::RUN_W'(st_rdata_q.svc);
	assign last_lv = lv_q == LW'(LEVELS - 1);
	assign lv_next = lv_q + LW'(1);

	always_comb begin
		res_d   = '0;
		emit    = 1'b0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == mlfs_pkg::REQ_TICK && any_queued) begin
						state_d = ST_SLOT;
					end else begin
						emit = 1'b1;
						if (req.req_type == mlfs_pkg::REQ_TICK) begin
							res_d.result_kind = mlfs_pkg::KIND_IDLE;
						end else if (any_free) begin
							res_d.result_kind = mlfs_pkg::KIND_ACCEPT;
						end else begin
							res_d.result_kind = mlfs_pkg::KIND_DROP;
						end
						state_d = out_free ? ST_IDLE : ST_HOLD;
					end
				end
			end
			ST_SLOT: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				emit              = 1'b1;
				res_d.result_kind = mlfs_pkg::KIND_RAN;
				res_d.ran_id      = st_rdata_q.id;
				res_d.ran_level   = mlfs_pkg::LVL_W'(lv_q);
				res_d.finished    = done;
				state_d           = out_free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: begin
				emit    = 1'b1;
				state_d = out_free ? ST_IDLE : ST_HOLD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign emit_res = (state_q == ST_HOLD) ? pend_q : res_d;

	always_comb begin
		st_we    = 1'b0;
		st_waddr = slot_q;
		st_wdata = '{id: st_rdata_q.id, svc: st_rdata_q.svc, run: run_new};
		ff_we    = 1'b0;
		ff_waddr = {lv_next, tail_q[lv_next]};
		ff_wdata = slot_q;
		if (state_q == ST_IDLE) begin
			st_waddr = free_slot;
			st_wdata = '{id: req.process_id, svc: req.service_time, run: '0};
			ff_waddr = {LW'(0), tail_q[0]};
			ff_wdata = free_slot;
			if (accept && req.req_type == mlfs_pkg::REQ_ARRIVAL && any_free) begin
				st_we = 1'b1;
				ff_we = 1'b1;
			end
		end else if (state_q == ST_CALC) begin
			st_we = 1'b1;
			ff_we = !done && !last_lv;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		st_rdata_q <= store_mem[ff_rdata_q];
	end

	always_ff @(posedge clk) begin
		if (ff_we) begin
			fifo_mem[ff_waddr] <= ff_wdata;
		end
		ff_rdata_q <= fifo_mem[{lv_sel, head_q[lv_sel]}];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			lv_q <= lv_sel;
		end
		if (state_q == ST_SLOT) begin
			slot_q <= ff_rdata_q;
		end
		if (emit && state_q != ST_HOLD) begin
			pend_q <= res_d;
		end
		if (emit && out_free) begin
			res_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quantum_q   <= mlfs_pkg::QUANTUM_RESET;
			res_valid_q <= 1'b0;
			in_use_q    <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (emit && out_free) begin
				res_valid_q <= 1'b1;
			end else if (out_free) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && accept && req.req_type == mlfs_pkg::REQ_ARRIVAL
					&& any_free) begin
				in_use_q[free_slot] <= 1'b1;
				tail_q[0]  <= (tail_q[0] == SW'(MAX_PROCS - 1)) ? '0 : tail_q[0] + SW'(1);
				count_q[0] <= count_q[0] + CW'(1);
			end
			if (state_q == ST_CALC && (done || !last_lv)) begin
				head_q[lv_q]  <= (head_q[lv_q] == SW'(MAX_PROCS - 1)) ? '0
					: head_q[lv_q] + SW'(1);
				count_q[lv_q] <= count_q[lv_q] - CW'(1);
				if (done) begin
					in_use_q[slot_q] <= 1'b0;
				end else begin
					tail_q[lv_next]  <= (tail_q[lv_next] == SW'(MAX_PROCS - 1)) ? '0
						: tail_q[lv_next] + SW'(1);
					count_q[lv_next] <= count_q[lv_next] + CW'(1);
				end
			end
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		total_queued = 0;
		for (int i = 0; i < LEVELS; i++) begin
			total_queued = total_queued + int'(count_q[i]);
		end
	end

	a_slots_match_queues: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_use_q) == total_queued)
		else $error("busy slots disagree with queued entries");

	a_calc_level_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> count_q[lv_q] != '0)
		else $error("tick update on an empty level");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind != mlfs_pkg::KIND_RAN |->
			res.ran_id == '0 && res.ran_level == '0 && !res.finished)
		else $error("non-run result carries run fields");

endmodule

`default_nettype wire

>>> dv/mlfs_checker.sv
// ----------------------------------------------------------------------------
// mlfs_checker
// Watches the request, result and quantum ports of the multilevel feedback
// scheduler, keeps its own copy of the process store and level queues,
// predicts the result of every accepted request beat and compares each
// accepted result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mlfs_checker
	import mlfs_pkg::*;
#(
	parameter int MAX_PROCS = 16,
	parameter int LEVELS    = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_stall,
	input  req_t                req,
	input  wire logic           res_valid,
	input  wire logic           res_stall,
	input  res_t                res,
	input  wire logic           cfg_we,
	input  wire logic [Q_W-1:0] cfg_wdata,
	output int                  fail_count,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_W = $clog2(MAX_PROCS);

	proc_entry_t          proc_table[MAX_PROCS];
	logic [MAX_PROCS-1:0] slot_busy;
	logic [SLOT_W-1:0]    level_q[LEVELS][$];
	logic [Q_W-1:0]       quantum;
	res_t                 pending_results[$];
	int                   mismatches;

	function automatic res_t schedule_step(req_t r);
		res_t o;
		int lv;
		int s;
		logic [SLOT_W-1:0] slot;
		o = '0;
		if (r.req_type == REQ_ARRIVAL) begin
			s = -1;
			for (int i = 0; i < MAX_PROCS; i++)
				if (s < 0 && !slot_busy[i])
					s = i;
			if (s < 0) begin
				o.result_kind = KIND_DROP;
				return o;
			end
			slot_busy[s] = 1'b1;
			proc_table[s] = '{id: r.process_id, svc: r.service_time, run: '0};
			level_q[0] = {level_q[0], SLOT_W'(s)};
			o.result_kind = KIND_ACCEPT;
			return o;
		end
		lv = -1;
		for (int i = 0; i < LEVELS; i++)
			if (lv < 0 && level_q[i].size() != 0)
				lv = i;
		if (lv < 0) begin
			o.result_kind = KIND_IDLE;
			return o;
		end
		slot = level_q[lv][0];
		proc_table[slot].run = proc_table[slot].run + RUN_W'(quantum);
		o.result_kind = KIND_RAN;
		o.ran_id      = proc_table[slot].id;
		o.ran_level   = LVL_W'(lv);
		o.finished    = proc_table[slot].run >= RUN_W'(proc_table[slot].svc);
		if (o.finished) begin
			level_q[lv].delete(0);
			slot_busy[slot] = 1'b0;
		end else if (lv + 1 < LEVELS) begin
			level_q[lv].delete(0);
			level_q[lv + 1] = {level_q[lv + 1], slot};
		end
		return o;
	endfunction

	task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t pred;
		if (!arst_n) begin
			slot_busy = '0;
			for (int i = 0; i < LEVELS; i++)
				level_q[i].delete();
			pending_results.delete();
			quantum = QUANTUM_RESET;
			mismatches = 0;
		end else begin
			if (cfg_we)
				quantum = cfg_wdata;
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, res);
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					check_field("result_kind", 8'(want.result_kind), 8'(res.result_kind));
					check_field("ran_id", want.ran_id, res.ran_id);
					check_field("ran_level", 8'(want.ran_level), 8'(res.ran_level));
					check_field("finished", 8'(want.finished), 8'(res.finished));
				end
			end
			if (req_valid && !req_stall) begin
				pred = schedule_step(req);
				pending_results = {pending_results, pred};
			end
		end
		fail_count  <= mismatches;
		outstanding <= pending_results.size();
	end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the multilevel feedback scheduler: a directed opening that
// hits the empty tick, zero and full-scale service times, duplicate ids and a
// full store, then phases of random arrivals and ticks under several quantum
// settings (0, 1, 10, 255 and random), each followed by a flush of the store.
// The sender works in bursts with gaps, the receiver stalls on its own
// pattern with two long hold-offs; mlfs_checker does the prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mlfs_pkg::*;

	localparam int MAX_PROCS       = 16;
	localparam int LEVELS          = 6;
	localparam int PHASES          = 6;
	localparam int PHASE_BEATS     = 80;
	localparam int HOLDOFF_CYCLES  = 400;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SETTLE_CYCLES   = 10;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	req_t           req       = '0;
	logic           res_valid;
	logic           res_stall = 1'b1;
	res_t           res;
	logic           cfg_we    = 1'b0;
	logic [Q_W-1:0] cfg_wdata = '0;

	int          fail_count;
	int          outstanding;
	int          idle_cycles = 0;
	logic [1:0]  last_kind = KIND_ACCEPT;
	bit          want_holdoff = 1'b0;
	int          holdoff_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          stall_phase = 0;
	int          burst_left = 0;
	int          max_gap = 0;

	multilevel_feedback_scheduler #(
		.MAX_PROCS(MAX_PROCS),
		.LEVELS   (LEVELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	mlfs_checker #(
		.MAX_PROCS(MAX_PROCS),
		.LEVELS   (LEVELS)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (res_valid && !res_stall)
			last_kind <= res.result_kind;
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: long hold-off on request, otherwise a stall pattern of its own
	initial begin
		forever begin
			@(posedge clk);
			if (want_holdoff && holdoff_left == 0) begin
				want_holdoff = 1'b0;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				res_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(50, 300);
				end else begin
					mode_left--;
				end
				stall_phase++;
				case (stall_mode)
					STALL_NONE:  res_stall <= 1'b0;
					STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
					default:     res_stall <= (stall_phase % 3 == 0);
				endcase
			end
		end
	end

	function automatic req_t make_item(int tick_pct, logic [Q_W-1:0] q);
		req_t r;
		r.req_type   = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_ARRIVAL;
		r.process_id = ID_W'($urandom);
		if (r.req_type == REQ_TICK)
			r.service_time = SVC_W'($urandom);
		else if ($urandom_range(0, 7) == 0)
			r.service_time = '0;
		else
			r.service_time = SVC_W'($urandom_range(0, int'(q) * 7 + 3));
		return r;
	endfunction

	function automatic req_t arrival(logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
		return '{req_type: REQ_ARRIVAL, process_id: id, service_time: svc};
	endfunction

	// offer one beat, hold it until accepted, then advance the burst
	task automatic send_beat(req_t item);
		int gap;
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_quantum(logic [Q_W-1:0] q);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// tick at full quantum until the block reports an idle tick
	task automatic flush_store();
		set_quantum('1);
		do begin
			send_beat(make_item(100, '0));
			drain();
		end while (last_kind != KIND_IDLE);
	endtask

	initial begin
		logic [Q_W-1:0] q;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		max_gap = 3;
		send_beat(make_item(100, '0));
		send_beat(arrival(8'h00, 16'h0000));
		send_beat(arrival(8'hFF, 16'hFFFF));
		send_beat(arrival(8'hAA, 16'd10));
		send_beat(arrival(8'h55, 16'd11));
		for (int i = 0; i < MAX_PROCS - 4; i++)
			send_beat(arrival(ID_W'(i), SVC_W'(i * 3)));
		send_beat(arrival(8'h00, 16'd1));
		repeat (4) send_beat(make_item(100, '0));
		flush_store();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       q = QUANTUM_RESET;
				1:       q = '0;
				2:       q = 8'd1;
				3:       q = '1;
				default: q = Q_W'($urandom);
			endcase
			set_quantum(q);
			max_gap = (p % 3 == 0) ? 0 : $urandom_range(1, 12);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if ((p == 1 || p == 4) && n == 40)
					want_holdoff = 1'b1;
				send_beat(make_item($urandom_range(35, 65), q));
			end
			flush_store();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
